// ----- rtl/pdot_pkg.sv -----
package pdot_pkg;

	// Largest radius the quarter store is sized for.
	localparam int unsigned MAX_RADIUS = 7;
	// Corners one quarter walk can record.
	localparam int unsigned QDEPTH = 2 * MAX_RADIUS + 1;

	localparam int unsigned RAD_W = 3;
	localparam int unsigned COORD_W = 4;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned LIM_W = 6;
	localparam int unsigned SUM_W = 8;
	localparam int unsigned HALF_W = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_X,
		ST_WALK_Y,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} pdot_state_t;

	// Quadrant order of the emitted outline.
	typedef enum logic [1:0] {
		QD_FWD     = 2'd0,
		QD_MIR_Y   = 2'd1,
		QD_MIR_XY  = 2'd2,
		QD_MIR_X   = 2'd3
	} pdot_quad_t;

	// Square of a small pixel coordinate.
	function automatic logic [SUM_W-1:0] pdot_sq(input logic [COORD_W-1:0] v);
		logic [2*COORD_W-1:0] p;
		p = {{COORD_W{1'b0}}, v} * {{COORD_W{1'b0}}, v};
		return p[SUM_W-1:0];
	endfunction

endpackage

// ----- rtl/pixel_disc_outline_tracer_unit.sv -----
// A request walks the quarter with one compare per cycle on the shared square-and-compare unit,
// then emits 4*n vertices, n <= 2*R+1, each through a quarter store read and then the output
// register, and any output stall holds the emit.
// The walk is skipped when the radius matches the stored walk or the radius is zero.
// A request with start_req clear is accepted in idle and starts nothing. No new item is taken until done.
// Reset clears the sequencer and the output valid, forgets any stored walk and sets the radius to 7.
module pixel_disc_outline_tracer_unit
	import pdot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,     // brush_radius
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [0] start_req, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,       // [4:0] vertex_x_half, [9:5] vertex_y_half, [15:10] zero
	output logic        m_tlast        // last_vertex
);

	pdot_state_t state_q, state_d;

	logic [RAD_W-1:0]   radius_q;
	logic               qvalid_q;
	logic [RAD_W-1:0]   qradius_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [LIM_W-1:0]   lim_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         quad_q;
	logic [CNT_W-1:0]   idx_q;
	logic [7:0]         rd_q;
	logic [7:0]         qmem [QDEPTH];

	logic               m_tvalid_q;
	logic [HALF_W-1:0]  vx_q, vy_q;
	logic               last_q;

	logic               start;
	logic               cache_hit;
	logic [LIM_W-1:0]   r_ext;
	logic [COORD_W-1:0] ux, uy;
	logic [SUM_W-1:0]   sum;
	logic               in_disc;
	logic               slot_free;
	logic               last_idx;
	logic               last_item;
	logic [CNT_W-1:0]   rd_addr;
	logic               rec_en;
	logic [CNT_W-1:0]   rec_addr;
	logic [7:0]         rec_data;
	logic               rd_en;
	logic               load_out;
	logic [HALF_W-1:0]  hx, hy;

	assign start     = s_tvalid && s_tready && s_tdata[0];
	assign cache_hit = qvalid_q && (qradius_q == radius_q);
	assign r_ext     = {{(LIM_W-RAD_W){1'b0}}, radius_q};
	assign slot_free = !m_tvalid_q || m_tready;
	assign last_idx  = (idx_q == cnt_q - 1'b1);
	assign last_item = last_idx && (quad_q == QD_MIR_X);

	// Shared unit: square both coordinates and compare the sum against R*R+R.
	always_comb begin
		if (state_q == ST_WALK_X) begin
			ux = x_q + 1'b1;
			uy = y_q;
		end else begin
			ux = x_q;
			uy = y_q - 1'b1;
		end
		sum     = pdot_sq(ux) + pdot_sq(uy);
		in_disc = (sum <= {{(SUM_W-LIM_W){1'b0}}, lim_q});
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cache_hit || radius_q == '0) state_d = ST_EMIT_RD;
					else state_d = ST_WALK_X;
				end
			end
			ST_WALK_X: begin
				if (!in_disc) state_d = ST_WALK_Y;
			end
			ST_WALK_Y: begin
				if (uy == '0) state_d = ST_EMIT_RD;
				else if (in_disc) state_d = ST_WALK_X;
			end
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (slot_free) state_d = last_item ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, store write and read, output load.
	always_comb begin
		s_tready = 1'b0;
		rec_en   = 1'b0;
		rec_addr = cnt_q;
		rec_data = {ux, uy};
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (start && !cache_hit) begin
					rec_en   = 1'b1;
					rec_addr = '0;
					rec_data = {{COORD_W{1'b0}}, {(COORD_W-RAD_W){1'b0}}, radius_q};
				end
			end
			ST_WALK_X:   rec_en = !in_disc && (cnt_q < CNT_W'(QDEPTH));
			ST_WALK_Y:   rec_en = in_disc && (cnt_q < CNT_W'(QDEPTH));
			ST_EMIT_RD:  rd_en = 1'b1;
			ST_EMIT_OUT: load_out = slot_free;
			default: ;
		endcase
	end

	// Read address: QD_FWD and QD_MIR_XY count up, QD_MIR_Y and QD_MIR_X count down.
	always_comb begin
		case (quad_q)
			QD_FWD, QD_MIR_XY: rd_addr = idx_q;
			default:           rd_addr = cnt_q - 1'b1 - idx_q;
		endcase
	end

	// Quarter store: written at the start and during the walk, read one entry per vertex.
	always_ff @(posedge clk) begin
		if (rec_en) qmem[rec_addr] <= rec_data;
		if (rd_en) rd_q <= qmem[rd_addr];
	end

	// Corner to half-pixel vertex with the quadrant's signs.
	always_comb begin
		hx = {1'b0, rd_q[7:4]} + {1'b0, rd_q[7:4]} - 1'b1;
		hy = {1'b0, rd_q[3:0]} + {1'b0, rd_q[3:0]} + 1'b1;
		if (quad_q == QD_MIR_XY || quad_q == QD_MIR_X) hx = -hx;
		if (quad_q == QD_MIR_Y || quad_q == QD_MIR_XY) hy = -hy;
	end

	// Control and walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			radius_q   <= RAD_W'(MAX_RADIUS);
			qvalid_q   <= 1'b0;
			qradius_q  <= '0;
			cnt_q      <= '0;
			quad_q     <= QD_FWD;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) radius_q <= cfg_wdata;
			// A fresh walk starts its count after the first corner.
			if (state_q == ST_IDLE && start && !cache_hit) cnt_q <= CNT_W'(1);
			else if (rec_en) cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_IDLE && start) begin
				quad_q <= QD_FWD;
				idx_q  <= '0;
				if (!cache_hit) begin
					qvalid_q  <= 1'b1;
					qradius_q <= radius_q;
				end
			end
			if (load_out) begin
				if (last_idx) begin
					idx_q  <= '0;
					quad_q <= pdot_quad_t'(quad_q + 1'b1);
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Walk coordinates and limit.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q   <= '0;
			y_q   <= {{(COORD_W-RAD_W){1'b0}}, radius_q};
			lim_q <= LIM_W'(r_ext * r_ext + r_ext);
		end else if (state_q == ST_WALK_X) begin
			x_q <= ux;
		end else if (state_q == ST_WALK_Y) begin
			y_q <= uy;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			vx_q   <= hx;
			vy_q   <= hy;
			last_q <= last_item;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, vy_q, vx_q};
	assign m_tlast  = last_q;

	// The corner count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("quarter count beyond store depth");

	// x never walks past one beyond the largest radius.
	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_X || state_q == ST_WALK_Y) |-> x_q <= COORD_W'(MAX_RADIUS + 1))
		else $error("walk x out of range");

	// The final vertex returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_item) |=> state_q == ST_IDLE)
		else $error("sequencer not idle after last vertex");

	// A new vertex is only presented from the emit state.
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_EMIT_OUT)
		else $error("output loaded outside emit");

endmodule
